[rtl/stereo_pan_level_mixer_assert.svh]
// Assertion macros for the stereo pan level mixer.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef STEREO_PAN_LEVEL_MIXER_ASSERT_SVH
`define STEREO_PAN_LEVEL_MIXER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define SPM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stereo_pan_level_mixer: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stereo_pan_level_mixer: next-cycle check failed");

`endif

[rtl/spm_pkg.sv]
// Shared types and constants for the stereo pan level mixer.
// No dependencies.
package spm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 9;
	localparam int LEVEL_W   = 8;
	localparam int ACC_W     = 32;
	localparam int OUT_W     = 16;
	localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
	localparam int PAN_SHIFT = 7;
	localparam int SCALED_W  = PROD_W - PAN_SHIFT;
	localparam int TERM_W    = SCALED_W + LEVEL_W + 1;
	localparam int OUT_SHIFT = 9;
	localparam int OUT_MAX_I = 32767;
	localparam int OUT_MIN_I = -32768;

	localparam logic signed [WEIGHT_W-1:0] UNITY_WEIGHT = 9'sd128;

	// One classified channel item as it waits in the item queue
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [WEIGHT_W-1:0] lw;
		logic signed [WEIGHT_W-1:0] rw;
		logic        [LEVEL_W-1:0]  level;
		logic                       last;
	} item_t;

	// One stereo frame result
	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} res_t;

endpackage

[rtl/spm_fifo.sv]
// Small synchronous queue with registered storage, used for items and results.
// No package dependencies.
module spm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/spm_front.sv]
// Front end: accept channel items, derive the pan weights, classify activity.
// Depends on spm_pkg.
module spm_front (
	input  logic                                push,
	output logic                                full,
	input  logic signed [spm_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [spm_pkg::WEIGHT_W-1:0] pan,
	input  logic        [spm_pkg::LEVEL_W-1:0]  level,
	input  logic                                active,
	input  logic                                last_channel,
	output logic                                q_push,
	output spm_pkg::item_t                      q_item,
	input  logic                                q_full
);
	import spm_pkg::*;

	logic pan_pos;
	logic pan_neg;

	assign full   = q_full;
	assign q_push = push;

	assign pan_neg = pan[WEIGHT_W-1];
	assign pan_pos = !pan[WEIGHT_W-1] && (pan != '0);

	// Build the item; an inactive channel gets zero weights and adds nothing
	always_comb begin
		q_item.sample = sample;
		q_item.level  = level;
		q_item.last   = last_channel;
		if (active) begin
			q_item.lw = pan_pos ? UNITY_WEIGHT - pan : UNITY_WEIGHT;
			q_item.rw = pan_neg ? UNITY_WEIGHT + pan : UNITY_WEIGHT;
		end else begin
			q_item.lw = '0;
			q_item.rw = '0;
		end
	end

endmodule

[rtl/spm_back.sv]
// Back end: weight and level products, frame accumulation, frame close.
// Depends on spm_pkg.
module spm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  spm_pkg::item_t q_item,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           r_push,
	output spm_pkg::res_t  r_data,
	input  logic           r_full
);
	import spm_pkg::*;

	localparam int QUO_W      = ACC_W - OUT_SHIFT;
	localparam int CLOSE_BIAS = (1 << OUT_SHIFT) - 1;

	// Divide by 512 toward zero and clamp to 16 bits
	function automatic logic signed [OUT_W-1:0] close_side(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] biased;
		logic signed [QUO_W-1:0] quo;
		biased = v[ACC_W-1] ? v + ACC_W'(CLOSE_BIAS) : v;
		quo    = biased[ACC_W-1:OUT_SHIFT];
		if (quo > QUO_W'(OUT_MAX_I)) begin
			return OUT_W'(OUT_MAX_I);
		end else if (quo < QUO_W'(OUT_MIN_I)) begin
			return OUT_W'(OUT_MIN_I);
		end
		return quo[OUT_W-1:0];
	endfunction

	logic                       adv;
	logic                       v_s1;
	logic signed [PROD_W-1:0]   prod_l_s1;
	logic signed [PROD_W-1:0]   prod_r_s1;
	logic        [LEVEL_W-1:0]  level_s1;
	logic                       last_s1;
	logic                       v_s2;
	logic signed [TERM_W-1:0]   term_l_s2;
	logic signed [TERM_W-1:0]   term_r_s2;
	logic                       last_s2;
	logic signed [SCALED_W-1:0] scaled_l;
	logic signed [SCALED_W-1:0] scaled_r;
	logic signed [ACC_W-1:0]    acc_l_q;
	logic signed [ACC_W-1:0]    acc_r_q;
	logic signed [ACC_W-1:0]    sum_l;
	logic signed [ACC_W-1:0]    sum_r;
	logic                       v_s3;
	logic signed [ACC_W-1:0]    frame_l_s3;
	logic signed [ACC_W-1:0]    frame_r_s3;

	// Hold the whole pipe while a closed frame cannot enter the result queue
	assign adv   = !(v_s3 && r_full);
	assign q_pop = adv && !q_empty;

	assign scaled_l = prod_l_s1[PROD_W-1:PAN_SHIFT];
	assign scaled_r = prod_r_s1[PROD_W-1:PAN_SHIFT];
	assign sum_l    = acc_l_q + ACC_W'(term_l_s2);
	assign sum_r    = acc_r_q + ACC_W'(term_r_s2);

	assign r_push       = v_s3 && !r_full;
	assign r_data.left  = close_side(frame_l_s3);
	assign r_data.right = close_side(frame_r_s3);

	// Stage payloads: sample times weight, then shifted product times level
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_l_s1 <= PROD_W'(q_item.sample) * PROD_W'(q_item.lw);
			prod_r_s1 <= PROD_W'(q_item.sample) * PROD_W'(q_item.rw);
			level_s1  <= q_item.level;
			last_s1   <= q_item.last;
			term_l_s2 <= TERM_W'(scaled_l) * TERM_W'($signed({1'b0, level_s1}));
			term_r_s2 <= TERM_W'(scaled_r) * TERM_W'($signed({1'b0, level_s1}));
			last_s2   <= last_s1;
			if (v_s2 && last_s2) begin
				frame_l_s3 <= sum_l;
				frame_r_s3 <= sum_r;
			end
		end
	end

	// Advance valid bits and accumulate; clear at frame close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (adv) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			if (v_s2) begin
				acc_l_q <= last_s2 ? '0 : sum_l;
				acc_r_q <= last_s2 ? '0 : sum_r;
			end
		end
	end

endmodule

[rtl/stereo_pan_level_mixer.sv]
// Top level of the stereo pan level mixer: front end, item queue, back end, result queue.
// Depends on spm_pkg, spm_fifo, spm_front, spm_back and stereo_pan_level_mixer_assert.svh.
//
// Channel items are pushed one per cycle while full is low; the block sustains one item
// per clock unless a closed frame waits on a full result queue, set by the accumulate
// adds in the back end, with the multiplies pipelined ahead of them. The frame closed by
// an item marked last_channel passes from the item queue through the two multiplier
// stages and the accumulate/close stage into the result queue. While the result queue
// is full and a closed frame waits, the back end holds, the item queue fills and full
// rises once ITEM_DEPTH items are waiting. Reset clears both accumulators at once.
`include "stereo_pan_level_mixer_assert.svh"

module stereo_pan_level_mixer #(
	parameter int ITEM_DEPTH = 4,
	parameter int RES_DEPTH  = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [spm_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [spm_pkg::WEIGHT_W-1:0] pan,
	input  logic        [spm_pkg::LEVEL_W-1:0]  level,
	input  logic                                active,
	input  logic                                last_channel,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [spm_pkg::OUT_W-1:0]    left_out,
	output logic signed [spm_pkg::OUT_W-1:0]    right_out
);
	import spm_pkg::*;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(res_t);

	logic              q_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	item_t             q_wr_item;
	logic [ITEM_W-1:0] q_rd_bits;
	item_t             q_rd_item;
	logic              r_push;
	logic              r_full;
	res_t              r_wr_data;
	logic [RES_W-1:0]  r_rd_bits;
	res_t              r_rd_data;

	assign q_rd_item = item_t'(q_rd_bits);
	assign r_rd_data = res_t'(r_rd_bits);
	assign left_out  = r_rd_data.left;
	assign right_out = r_rd_data.right;

	// Classify incoming channel items
	spm_front u_front (
		.push         (push),
		.full         (full),
		.sample       (sample),
		.pan          (pan),
		.level        (level),
		.active       (active),
		.last_channel (last_channel),
		.q_push       (q_push),
		.q_item       (q_wr_item),
		.q_full       (q_full)
	);

	// Decouple front and back
	spm_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (ITEM_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_bits),
		.empty   (q_empty)
	);

	// Mix and close frames
	spm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_rd_item),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.r_push  (r_push),
		.r_data  (r_wr_data),
		.r_full  (r_full)
	);

	// Hold closed frames until taken
	spm_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (r_push),
		.wr_data (r_wr_data),
		.full    (r_full),
		.rd_en   (pop),
		.rd_data (r_rd_bits),
		.empty   (empty)
	);

	`SPM_ASSERT_NOW(a_res_no_overflow, r_push, !r_full)
	`SPM_ASSERT_NOW(a_item_no_underflow, q_pop, !q_empty)
	`SPM_ASSERT_NEXT(a_accept_fills_queue, push && !full, !q_empty)

endmodule
